// ===== rtl/core/psde_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the PNG stored-deflate encoder.
`timescale 1ns / 1ps
`default_nettype none
package psde_pkg;

  localparam int unsigned BlockMaxDefault = 65535;
  localparam int unsigned MaxResults      = 43;
  localparam logic [31:0] CrcPoly         = 32'hEDB88320;
  localparam logic [31:0] AllOnes         = 32'hFFFFFFFF;
  localparam logic [16:0] AdlerMod        = 17'd65521;
  localparam logic [14:0] DimMax          = 15'd16384;

  localparam logic [1:0] RegImageWidth  = 2'd0;
  localparam logic [1:0] RegImageHeight = 2'd1;

  localparam logic FuncStart = 1'b0;
  localparam logic FuncPixel = 1'b1;

  typedef enum logic [2:0] {
    M_IDLE,
    M_START,
    M_RAW,
    M_FIN,
    M_ERR
  } mode_e;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_end;
    logic       misuse;
  } out_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/psde_if.sv =====
// Valid/ready stream interfaces for pixel items and output bytes.
`timescale 1ns / 1ps
`default_nettype none
interface psde_in_if;
  import psde_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psde_out_if;
  import psde_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/png_stored_deflate_encoder_top.sv =====
// An accepted item sets the mode register; each byte is then registered in the output register,
// one byte per cycle while the receiver is ready. A start item gives 43 bytes; a pixel 4 or 5,
// plus 5 per block header and 20 for the trailer on the last pixel.
// The IDAT length comes from a reciprocal multiply spread over the first two header bytes.
// Reset is asynchronous, active low; it clears control state and sets both dimensions to 1.
`timescale 1ns / 1ps
`default_nettype none
module png_stored_deflate_encoder_top
  import psde_pkg::*;
#(
  parameter int unsigned STORED_BLOCK_MAX = BlockMaxDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [14:0] cfg_data_i,
  psde_in_if.sink     in_i,
  psde_out_if.source  out_o
);

  localparam logic [15:0] BlkMax = 16'(STORED_BLOCK_MAX);
  localparam logic [5:0]  EmitLimit = 6'(MaxResults);
  // floor(x / block max) as (x * DivMul) >> DivShift, exact for dividends below 2^31
  localparam int unsigned DivShift = 31 + $clog2(STORED_BLOCK_MAX);
  localparam logic [63:0] DivMul =
    ((64'd1 << DivShift) + 64'(STORED_BLOCK_MAX) - 64'd1) / 64'(STORED_BLOCK_MAX);

  logic [14:0] cfg_w_q, cfg_h_q;
  mode_e       mode_q, mode_d;
  logic [5:0]  cnt_q, cnt_d, emit_q, emit_d;
  logic [2:0]  slot_q, slot_d, hdr_q, hdr_d;
  logic        in_hdr_q, in_hdr_d, last_pix_q;
  logic [31:0] crc_q, crc_d, raw_q, raw_left_q, raw_left_d, q_q, q_d;
  logic [15:0] blk_left_q, blk_left_d, alo_q, alo_d, ahi_q, ahi_d;
  logic [13:0] col_q, row_q;
  logic        frame_open_q;
  logic [14:0] w_q, h_q;
  logic [7:0]  pix_q [4];
  logic        ov_q;
  out_item_t   od_q;

  logic [14:0] w_cl, h_cl;
  logic        adv, accept, last_byte, crc_en, crc_rst, fend, mis, drop, data_byte;
  logic [7:0]  b;
  logic [15:0] take;
  logic        bfinal;
  logic [31:0] blocks, idat, crc_x;
  logic [16:0] alo_s, ahi_s;
  logic [62:0] div_prod;

  function automatic logic [14:0] clamp_dim(input logic [14:0] v);
    if (v == 15'd0) return 15'd1;
    if (v > DimMax) return DimMax;
    return v;
  endfunction

  assign w_cl = clamp_dim(cfg_w_q);
  assign h_cl = clamp_dim(cfg_h_q);

  assign adv    = (mode_q != M_IDLE) && (!ov_q || out_o.ready);
  assign in_i.ready = (mode_q == M_IDLE) || (adv && last_byte);
  assign accept = in_i.valid && in_i.ready;
  assign drop   = emit_q >= EmitLimit;

  assign take   = (raw_left_q == 32'd0) ? 16'd1 :
                  (raw_left_q < {16'd0, BlkMax}) ? raw_left_q[15:0] : BlkMax;
  assign bfinal = {16'd0, take} >= raw_left_q;
  // q_q holds raw + block max - 1 after the first header byte, the block count after the second
  assign div_prod = 63'(q_q[30:0]) * 63'(DivMul[31:0]);
  assign blocks = q_q;
  assign idat   = raw_q + {blocks[29:0], 2'b00} + blocks + 32'd6;
  assign crc_x  = crc_q ^ AllOnes;

  // byte generator
  always_comb begin
    b = 8'h00; crc_en = 1'b0; crc_rst = 1'b0; last_byte = 1'b0;
    fend = 1'b0; mis = 1'b0; data_byte = 1'b0;
    unique case (mode_q)
      M_START: begin
        case (cnt_q)
          6'd0: b = 8'h89;  6'd1: b = 8'h50;  6'd2: b = 8'h4E;  6'd3: b = 8'h47;
          6'd4: b = 8'h0D;  6'd5: b = 8'h0A;  6'd6: b = 8'h1A;  6'd7: b = 8'h0A;
          6'd11: b = 8'h0D;
          6'd12: b = "I";   6'd13: b = "H";   6'd14: b = "D";   6'd15: b = "R";
          6'd18: b = {1'b0, w_q[14:8]};       6'd19: b = w_q[7:0];
          6'd22: b = {1'b0, h_q[14:8]};       6'd23: b = h_q[7:0];
          6'd24: b = 8'h08; 6'd25: b = 8'h06;
          6'd29: b = crc_x[31:24]; 6'd30: b = crc_x[23:16];
          6'd31: b = crc_x[15:8];  6'd32: b = crc_x[7:0];
          6'd33: b = idat[31:24];  6'd34: b = idat[23:16];
          6'd35: b = idat[15:8];   6'd36: b = idat[7:0];
          6'd37: b = "I";   6'd38: b = "D";   6'd39: b = "A";   6'd40: b = "T";
          6'd41: b = 8'h78; 6'd42: b = 8'h01;
          default: b = 8'h00;
        endcase
        crc_en    = (cnt_q >= 6'd12 && cnt_q <= 6'd28) || cnt_q >= 6'd37;
        crc_rst   = (cnt_q == 6'd12) || (cnt_q == 6'd37);
        last_byte = cnt_q == 6'd42;
      end
      M_RAW: begin
        crc_en = 1'b1;
        if (in_hdr_q || blk_left_q == 16'd0) begin
          case (in_hdr_q ? hdr_q : 3'd0)
            3'd0:    b = {7'd0, bfinal};
            3'd1:    b = take[7:0];
            3'd2:    b = take[15:8];
            3'd3:    b = ~take[7:0];
            default: b = ~take[15:8];
          endcase
        end else begin
          data_byte = 1'b1;
          b = (slot_q == 3'd0) ? 8'h00 : pix_q[slot_q[1:0] - 2'd1];
          last_byte = (slot_q == 3'd4) && !last_pix_q;
        end
      end
      M_FIN: begin
        case (cnt_q)
          6'd0: b = ahi_q[15:8];  6'd1: b = ahi_q[7:0];
          6'd2: b = alo_q[15:8];  6'd3: b = alo_q[7:0];
          6'd4: b = crc_x[31:24]; 6'd5: b = crc_x[23:16];
          6'd6: b = crc_x[15:8];  6'd7: b = crc_x[7:0];
          6'd12: b = "I"; 6'd13: b = "E"; 6'd14: b = "N"; 6'd15: b = "D";
          6'd16: b = crc_x[31:24]; 6'd17: b = crc_x[23:16];
          6'd18: b = crc_x[15:8];  6'd19: b = crc_x[7:0];
          default: b = 8'h00;
        endcase
        crc_en    = cnt_q <= 6'd3 || (cnt_q >= 6'd12 && cnt_q <= 6'd15);
        crc_rst   = cnt_q == 6'd12;
        last_byte = cnt_q == 6'd19;
        fend      = last_byte;
      end
      M_ERR: begin
        mis = 1'b1;
        last_byte = 1'b1;
      end
      default: ;
    endcase
  end

  assign alo_s = {1'b0, alo_q} + {9'd0, b};
  assign ahi_s = {1'b0, ahi_q} + {1'b0, alo_d};

  // sequencer next state
  always_comb begin
    mode_d = mode_q; cnt_d = cnt_q; slot_d = slot_q; hdr_d = hdr_q; in_hdr_d = in_hdr_q;
    crc_d = crc_q; raw_left_d = raw_left_q; blk_left_d = blk_left_q;
    alo_d = alo_q; ahi_d = ahi_q; q_d = q_q;
    emit_d = emit_q;
    if (adv) begin
      if (!drop) emit_d = emit_q + 6'd1;
      if (crc_en) crc_d = crc_byte(crc_rst ? AllOnes : crc_q, b);
      cnt_d = cnt_q + 6'd1;
      unique case (mode_q)
        M_START: begin
          if (cnt_q == 6'd0) begin
            raw_left_d = raw_q;
            blk_left_d = 16'd0;
            alo_d = 16'd1;
            ahi_d = 16'd0;
            q_d   = raw_q + {16'd0, BlkMax} - 32'd1;
          end
          if (cnt_q == 6'd1) q_d = 32'(div_prod >> DivShift);
          if (last_byte) mode_d = M_IDLE;
        end
        M_RAW: begin
          if (data_byte) begin
            alo_d = (alo_s >= AdlerMod) ? 16'(alo_s - AdlerMod) : alo_s[15:0];
            if (blk_left_q != 16'd0) blk_left_d = blk_left_q - 16'd1;
            if (raw_left_q != 32'd0) raw_left_d = raw_left_q - 32'd1;
            slot_d = slot_q + 3'd1;
            if (slot_q == 3'd4) begin
              mode_d = last_pix_q ? M_FIN : M_IDLE;
              cnt_d  = 6'd0;
            end
          end else if (in_hdr_q && hdr_q == 3'd4) begin
            in_hdr_d   = 1'b0;
            blk_left_d = take;
          end else begin
            in_hdr_d = 1'b1;
            hdr_d    = in_hdr_q ? hdr_q + 3'd1 : 3'd1;
          end
        end
        default: if (last_byte) mode_d = M_IDLE;
      endcase
    end
    if (data_byte && adv) begin
      ahi_d = (ahi_s >= AdlerMod) ? 16'(ahi_s - AdlerMod) : ahi_s[15:0];
    end
    if (accept) begin
      cnt_d = 6'd0; emit_d = 6'd0; in_hdr_d = 1'b0; hdr_d = 3'd0;
      if (in_i.data.func == FuncStart) mode_d = M_START;
      else if (!frame_open_q) mode_d = M_ERR;
      else begin
        mode_d = M_RAW;
        slot_d = (col_q == 14'd0) ? 3'd0 : 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 15'd1; cfg_h_q <= 15'd1;
      mode_q <= M_IDLE; cnt_q <= 6'd0; emit_q <= 6'd0;
      slot_q <= 3'd0; hdr_q <= 3'd0; in_hdr_q <= 1'b0; last_pix_q <= 1'b0;
      crc_q <= AllOnes; alo_q <= 16'd1; ahi_q <= 16'd0;
      blk_left_q <= 16'd0; raw_left_q <= 32'd0; q_q <= 32'd0;
      col_q <= 14'd0; row_q <= 14'd0; frame_open_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegImageWidth) cfg_w_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == RegImageHeight) cfg_h_q <= cfg_data_i;
      mode_q <= mode_d; cnt_q <= cnt_d; emit_q <= emit_d;
      slot_q <= slot_d; hdr_q <= hdr_d; in_hdr_q <= in_hdr_d;
      crc_q <= crc_d; alo_q <= alo_d; ahi_q <= ahi_d;
      blk_left_q <= blk_left_d; raw_left_q <= raw_left_d; q_q <= q_d;
      if (adv && !drop) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
      if (accept) begin
        if (in_i.data.func == FuncStart) begin
          frame_open_q <= 1'b1; col_q <= 14'd0; row_q <= 14'd0;
        end else if (frame_open_q) begin
          last_pix_q <= 1'b0;
          if ({1'b0, col_q} + 15'd1 >= w_cl) begin
            col_q <= 14'd0;
            if ({1'b0, row_q} + 15'd1 >= h_cl) begin
              row_q <= 14'd0; frame_open_q <= 1'b0; last_pix_q <= 1'b1;
            end else row_q <= row_q + 14'd1;
          end else col_q <= col_q + 14'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q[0] <= in_i.data.red;  pix_q[1] <= in_i.data.green;
      pix_q[2] <= in_i.data.blue; pix_q[3] <= in_i.data.alpha;
      if (in_i.data.func == FuncStart) begin
        w_q <= w_cl; h_q <= h_cl;
        raw_q <= 32'({17'd0, h_cl} * ({15'd0, w_cl, 2'b00} + 32'd1));
      end
    end
    if (adv && !drop) begin
      od_q.out_byte <= b;
      od_q.run_last <= last_byte || (emit_q == EmitLimit - 6'd1);
      od_q.file_end <= fend;
      od_q.misuse   <= mis;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = od_q;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_START && cnt_q < 6'd42) |-> !in_i.ready)
    else $error("input taken while headers are still being sent");
  a_misuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.misuse) |-> (out_o.data.out_byte == 8'h00 && out_o.data.run_last))
    else $error("error byte malformed");
  a_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.file_end) |-> out_o.data.run_last)
    else $error("file end without run end");
  a_hdr_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && mode_q == M_RAW && in_hdr_q && hdr_q == 3'd4) |=> blk_left_q != 16'd0)
    else $error("block opened with zero length");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the PNG stored-deflate encoder: directed table, random frames, then a closing frame.
`timescale 1ns / 1ps
module tb_top;
  import psde_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = RegImageWidth;
  logic [14:0] cfg_data_i = '0;

  psde_in_if  in_if ();
  psde_out_if out_if ();

  png_stored_deflate_encoder_top i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Encoder model state
  logic [14:0] enc_w = 15'd1, enc_h = 15'd1;
  logic [31:0] enc_crc = AllOnes, enc_raw_left = '0;
  logic [15:0] enc_alo = 16'd1, enc_ahi = '0, enc_blk_left = '0;
  logic [13:0] enc_col = '0, enc_row = '0;
  logic        enc_open = 1'b0;
  out_item_t   step_bytes[$];
  out_item_t   png_expected[$];
  int          errors = 0;
  bit          quiet = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [31:0] clamp_dim(input logic [14:0] v);
    if (v == 0) return 32'd1;
    if (v > DimMax) return 32'd16384;
    return {17'd0, v};
  endfunction

  task automatic emit(input logic [7:0] b, input logic endf);
    out_item_t o;
    o = '{out_byte: b, run_last: 1'b0, file_end: endf, misuse: 1'b0};
    if (step_bytes.size() < MaxResults) step_bytes.insert(step_bytes.size(), o);
  endtask

  task automatic emit_crc(input logic [7:0] b);
    logic [31:0] c;
    c = enc_crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    enc_crc = c;
    emit(b, 1'b0);
  endtask

  task automatic emit_be32(input logic [31:0] v, input bit with_crc);
    for (int s = 24; s >= 0; s -= 8) begin
      if (with_crc) emit_crc(v[s+:8]);
      else emit(v[s+:8], 1'b0);
    end
  endtask

  task automatic emit_raw(input logic [7:0] b);
    logic [31:0] take;
    logic [15:0] inv;
    if (enc_blk_left == 0) begin
      take = (enc_raw_left < 32'(BlockMaxDefault)) ? enc_raw_left : 32'(BlockMaxDefault);
      if (take == 0) take = 32'd1;
      inv = ~take[15:0];
      emit_crc((take >= enc_raw_left) ? 8'd1 : 8'd0);
      emit_crc(take[7:0]);
      emit_crc(take[15:8]);
      emit_crc(inv[7:0]);
      emit_crc(inv[15:8]);
      enc_blk_left = take[15:0];
    end
    emit_crc(b);
    enc_alo = 16'((32'(enc_alo) + 32'(b)) % 32'd65521);
    enc_ahi = 16'((32'(enc_ahi) + 32'(enc_alo)) % 32'd65521);
    if (enc_blk_left != 0) enc_blk_left--;
    if (enc_raw_left != 0) enc_raw_left--;
  endtask

  task automatic encode_start();
    logic [7:0]  sig[8];
    logic [31:0] w, h;
    logic [63:0] raw, blocks, idat_len;
    sig = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    w = clamp_dim(enc_w);
    h = clamp_dim(enc_h);
    raw = 64'(h) * (64'd1 + 64'd4 * 64'(w));
    blocks = (raw + 64'(BlockMaxDefault) - 64'd1) / 64'(BlockMaxDefault);
    idat_len = raw + 64'd5 * blocks + 64'd6;
    foreach (sig[i]) emit(sig[i], 1'b0);
    emit_be32(32'd13, 1'b0);
    enc_crc = AllOnes;
    emit_crc("I"); emit_crc("H"); emit_crc("D"); emit_crc("R");
    emit_be32(w, 1'b1);
    emit_be32(h, 1'b1);
    emit_crc(8'd8); emit_crc(8'd6); emit_crc(8'd0); emit_crc(8'd0); emit_crc(8'd0);
    emit_be32(enc_crc ^ AllOnes, 1'b0);
    emit_be32(idat_len[31:0], 1'b0);
    enc_crc = AllOnes;
    emit_crc("I"); emit_crc("D"); emit_crc("A"); emit_crc("T");
    emit_crc(8'h78); emit_crc(8'h01);
    enc_alo = 16'd1;
    enc_ahi = 16'd0;
    enc_blk_left = '0;
    enc_raw_left = raw[31:0];
    enc_col = '0;
    enc_row = '0;
    enc_open = 1'b1;
  endtask

  task automatic encode_finish();
    logic [31:0] c;
    emit_be32({enc_ahi, enc_alo}, 1'b1);
    emit_be32(enc_crc ^ AllOnes, 1'b0);
    emit_be32(32'd0, 1'b0);
    enc_crc = AllOnes;
    emit_crc("I"); emit_crc("E"); emit_crc("N"); emit_crc("D");
    c = enc_crc ^ AllOnes;
    emit(c[31:24], 1'b0);
    emit(c[23:16], 1'b0);
    emit(c[15:8], 1'b0);
    emit(c[7:0], 1'b1);
    enc_open = 1'b0;
  endtask

  // Predict the bytes of one accepted transaction and queue them unless a typed expectation replaces them.
  task automatic encode_item(input in_item_t it, input bit keep);
    out_item_t o;
    step_bytes.delete();
    if (it.func == FuncStart) begin
      encode_start();
    end else if (!enc_open) begin
      o = '{out_byte: 8'd0, run_last: 1'b0, file_end: 1'b0, misuse: 1'b1};
      step_bytes.insert(step_bytes.size(), o);
    end else begin
      if (enc_col == 0) emit_raw(8'd0);
      emit_raw(it.red);
      emit_raw(it.green);
      emit_raw(it.blue);
      emit_raw(it.alpha);
      if (32'(enc_col) + 1 >= clamp_dim(enc_w)) begin
        enc_col = '0;
        if (32'(enc_row) + 1 >= clamp_dim(enc_h)) begin
          enc_row = '0;
          encode_finish();
        end else begin
          enc_row = enc_row + 1'b1;
        end
      end else begin
        enc_col = enc_col + 1'b1;
      end
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].run_last = 1'b1;
    if (keep) foreach (step_bytes[i]) png_expected.insert(png_expected.size(), step_bytes[i]);
  endtask

  // Typed expectations for directed rows; the model still advances.
  bit        use_typed = 1'b0;
  out_item_t typed_exp;

  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      if (cfg_idx_i == RegImageWidth) enc_w = cfg_data_i;
      else if (cfg_idx_i == RegImageHeight) enc_h = cfg_data_i;
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      encode_item(in_if.data, !use_typed);
      if (use_typed) png_expected.insert(png_expected.size(), typed_exp);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (png_expected.size() == 0) begin
        report($sformatf("unexpected byte %02h", out_if.data.out_byte));
      end else begin
        want = png_expected.pop_front();
        if (out_if.data.out_byte !== want.out_byte)
          report($sformatf("out_byte %02h, want %02h", out_if.data.out_byte, want.out_byte));
        if (out_if.data.run_last !== want.run_last)
          report($sformatf("run_last %b, want %b", out_if.data.run_last, want.run_last));
        if (out_if.data.file_end !== want.file_end)
          report($sformatf("file_end %b, want %b", out_if.data.file_end, want.file_end));
        if (out_if.data.misuse !== want.misuse)
          report($sformatf("misuse %b, want %b", out_if.data.misuse, want.misuse));
      end
    end
  end

  // Receiver stalls in bursts.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
    end
  end

  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data  = it;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (png_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic in_item_t rand_pixel();
    in_item_t it;
    it.func  = FuncPixel;
    it.red   = 8'($urandom);
    it.green = 8'($urandom);
    it.blue  = 8'($urandom);
    it.alpha = 8'($urandom);
    return it;
  endfunction

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [14:0] val;
    in_item_t    item;
    bit          typed;
    out_item_t   exp;
  } stim_row_t;

  localparam out_item_t MisuseByte = '{out_byte: 8'd0, run_last: 1'b1, file_end: 1'b0,
                                       misuse: 1'b1};

  stim_row_t dir_rows[$];

  task automatic add_row(input stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  function automatic stim_row_t row_item(input logic f, input logic [31:0] px,
                                         input bit typed);
    stim_row_t r;
    r.is_cfg = 1'b0; r.idx = RegImageWidth; r.val = '0;
    r.item = {f, px};
    r.typed = typed;
    r.exp = MisuseByte;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input logic [1:0] idx, input logic [14:0] val);
    stim_row_t r;
    r = row_item(FuncStart, 32'd0, 1'b0);
    r.is_cfg = 1'b1; r.idx = idx; r.val = val;
    return r;
  endfunction

  initial begin
    int w, h, n;
    in_if.valid = 1'b0;
    in_if.data  = '0;

    add_row(row_item(FuncPixel, 32'h12345678, 1'b1));   // no frame open
    add_row(row_item(FuncStart, 32'd0, 1'b0));
    add_row(row_item(FuncPixel, 32'hFFFFFFFF, 1'b0));   // closes 1x1 frame
    add_row(row_item(FuncPixel, 32'h00000000, 1'b1));
    add_row(row_cfg(RegImageWidth, 15'd0));              // clamps to 1
    add_row(row_cfg(RegImageHeight, 15'h7FFF));          // clamps to 16384
    add_row(row_item(FuncStart, 32'hFFFFFFFF, 1'b0));   // channels ignored
    add_row(row_item(FuncPixel, 32'h00000000, 1'b0));
    add_row(row_item(FuncStart, 32'd0, 1'b0));           // abandon open frame
    add_row(row_cfg(RegImageWidth, 15'd16384));
    add_row(row_cfg(RegImageHeight, 15'd16384));
    add_row(row_item(FuncStart, 32'd0, 1'b0));
    add_row(row_item(FuncPixel, 32'hFF00FF00, 1'b0));
    add_row(row_item(FuncPixel, 32'h00FF00FF, 1'b0));
    add_row(row_cfg(RegImageWidth, 15'd2));
    add_row(row_cfg(RegImageHeight, 15'd2));
    add_row(row_item(FuncStart, 32'd0, 1'b0));
    add_row(row_item(FuncPixel, 32'hFFFFFFFF, 1'b0));
    add_row(row_item(FuncPixel, 32'h00000000, 1'b0));
    add_row(row_item(FuncPixel, 32'h80808080, 1'b0));
    add_row(row_item(FuncPixel, 32'h7F7F7F7F, 1'b0));
    add_row(row_item(FuncPixel, 32'hAAAAAAAA, 1'b1));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        use_typed = dir_rows[i].typed;
        typed_exp = dir_rows[i].exp;
        send_item(dir_rows[i].item);
        @(negedge clk_i);
        use_typed = 1'b0;
        in_if.valid = 1'b0;
      end
    end

    // Random frames, mostly well formed, with stray pixels and abandoned starts.
    n = 0;
    while (n < 400) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
      h = $urandom_range(1, 4);
      write_reg(RegImageWidth, 15'(w));
      write_reg(RegImageHeight, 15'(h));
      if ($urandom_range(0, 5) == 0) begin
        send_item(rand_pixel());
        n++;
      end
      send_item({FuncStart, 32'($urandom)});
      n++;
      if ($urandom_range(0, 7) == 0) begin
        for (int k = $urandom_range(0, w * h - 1); k > 0; k--) begin
          send_item(rand_pixel());
          n++;
        end
        send_item({FuncStart, 32'($urandom)});
        n++;
      end
      for (int k = 0; k < w * h; k++) begin
        send_item(rand_pixel());
        n++;
      end
    end

    // Closing frame and a stray pixel, with both sides kept busy.
    quiet = 1'b1;
    write_reg(RegImageWidth, 15'd6);
    write_reg(RegImageHeight, 15'd6);
    send_item({FuncStart, 32'd0});
    for (int k = 0; k < 6 * 6; k++) send_item(rand_pixel());
    send_item(rand_pixel());

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && png_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
